// ===== sv/sspp_pkg.sv =====
// servo status packet parser: shared types, codes and constants
// no dependencies; imported by the interfaces and all modules
`timescale 1ns / 1ps
`default_nettype none

package sspp_pkg;

    localparam int BYTE_W   = 8;
    localparam int TICK_W   = 16;
    localparam int EVENT_W  = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TICK_W;

    localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] MIN_LEN  = 8'd2;
    localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;

    localparam logic [BYTE_W-1:0] EXPECTED_ID_RST   = 8'd1;
    localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 16'd3000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED_ID   = 1'b0,
        CFG_TIMEOUT_TICKS = 1'b1
    } cfg_index_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_PARAM   = 3'd0,
        EV_GOOD    = 3'd1,
        EV_HEADER  = 3'd2,
        EV_ID      = 3'd3,
        EV_CSUM    = 3'd4,
        EV_TIMEOUT = 3'd5
    } event_t;

    typedef enum logic [6:0] {
        PH_HDR1   = 7'b0000001,
        PH_HDR2   = 7'b0000010,
        PH_ID     = 7'b0000100,
        PH_LEN    = 7'b0001000,
        PH_STATUS = 7'b0010000,
        PH_PARAM  = 7'b0100000,
        PH_CSUM   = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic              mode;
        logic [BYTE_W-1:0] rx_byte;
    } item_t;

    typedef struct packed {
        event_t            event_res;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] param_index;
        logic [BYTE_W-1:0] servo_error;
        logic [BYTE_W-1:0] param_count;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [BYTE_W-1:0] expected_id;
        logic [TICK_W-1:0] timeout_ticks;
    } cfg_t;

endpackage

`default_nettype wire

// ===== sv/sspp_item_if.sv =====
// input channel: received byte or time tick, valid/ready handshake
// depends on sspp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sspp_item_if
    import sspp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/sspp_result_if.sv =====
// output channel: parser events, valid/ready handshake
// depends on sspp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sspp_result_if
    import sspp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;
    logic [BYTE_W-1:0]  data_byte;
    logic [BYTE_W-1:0]  param_index;
    logic [BYTE_W-1:0]  servo_error;
    logic [BYTE_W-1:0]  param_count;
    logic               last;

    modport source (output valid, output event_res, output data_byte, output param_index,
                    output servo_error, output param_count, output last, input ready);
    modport sink   (input valid, input event_res, input data_byte, input param_index,
                    input servo_error, input param_count, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/sspp_core.sv =====
// packet state registers and the one-step parse logic
// depends on sspp_pkg
`timescale 1ns / 1ps
`default_nettype none

module sspp_core
    import sspp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step_valid,
    input  wire item_t   step_item,
    input  wire cfg_t    cfg,
    output logic         res_valid,
    output result_t      res
);

    phase_t            phase_reg, phase_next;
    logic              first_ok_reg, first_ok_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] left_reg, left_next;
    logic [BYTE_W-1:0] seen_reg, seen_next;
    logic [BYTE_W-1:0] status_reg, status_next;
    logic [TICK_W-1:0] idle_reg, idle_next;

    logic [TICK_W-1:0] idle_inc;
    logic [BYTE_W-1:0] rx_b;
    logic [BYTE_W-1:0] left_dec;
    logic [BYTE_W-1:0] csum_expect;
    event_t            ev;
    logic              emit;
    logic              ends;

    assign rx_b        = step_item.rx_byte;
    assign idle_inc    = (idle_reg == TICK_MAX) ? idle_reg : idle_reg + 1'b1;
    assign left_dec    = left_reg - 1'b1;
    assign csum_expect = HDR_BYTE - sum_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        first_ok_next = first_ok_reg;
        sum_next      = sum_reg;
        left_next     = left_reg;
        seen_next     = seen_reg;
        status_next   = status_reg;
        idle_next     = idle_reg;
        emit          = 1'b0;
        ends          = 1'b0;
        ev            = EV_PARAM;

        if (step_valid)
        begin
            if (step_item.mode)
            begin
                if (phase_reg != PH_HDR1)
                begin
                    idle_next = idle_inc;
                    if (idle_inc >= cfg.timeout_ticks)
                    begin
                        emit = 1'b1;
                        ends = 1'b1;
                        ev   = EV_TIMEOUT;
                    end
                end
            end
            else
            begin
                idle_next = '0;
                case (phase_reg)
                    PH_HDR1:
                    begin
                        first_ok_next = (rx_b == HDR_BYTE);
                        sum_next      = '0;
                        left_next     = '0;
                        seen_next     = '0;
                        status_next   = '0;
                        phase_next    = PH_HDR2;
                    end
                    PH_HDR2:
                    begin
                        if (!first_ok_reg || rx_b != HDR_BYTE)
                        begin
                            emit = 1'b1;
                            ends = 1'b1;
                            ev   = EV_HEADER;
                        end
                        else
                        begin
                            phase_next = PH_ID;
                        end
                    end
                    PH_ID:
                    begin
                        if (rx_b != cfg.expected_id)
                        begin
                            emit = 1'b1;
                            ends = 1'b1;
                            ev   = EV_ID;
                        end
                        else
                        begin
                            sum_next   = sum_reg + rx_b;
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        sum_next   = sum_reg + rx_b;
                        left_next  = (rx_b >= MIN_LEN) ? rx_b - MIN_LEN : '0;
                        phase_next = PH_STATUS;
                    end
                    PH_STATUS:
                    begin
                        sum_next    = sum_reg + rx_b;
                        status_next = rx_b;
                        phase_next  = (left_reg != '0) ? PH_PARAM : PH_CSUM;
                    end
                    PH_PARAM:
                    begin
                        sum_next  = sum_reg + rx_b;
                        seen_next = seen_reg + 1'b1;
                        left_next = left_dec;
                        if (left_dec == '0)
                        begin
                            phase_next = PH_CSUM;
                        end
                        emit = 1'b1;
                        ev   = EV_PARAM;
                    end
                    PH_CSUM:
                    begin
                        emit = 1'b1;
                        ends = 1'b1;
                        ev   = (csum_expect == rx_b) ? EV_GOOD : EV_CSUM;
                    end
                    default:
                    begin
                        phase_next = PH_HDR1;
                    end
                endcase
            end
            if (ends)
            begin
                phase_next = PH_HDR1;
            end
        end
    end

    assign res_valid       = emit;
    assign res.event_res   = ev;
    assign res.data_byte   = (ev == EV_PARAM) ? rx_b : '0;
    assign res.param_index = (ev == EV_PARAM) ? seen_reg : '0;
    assign res.servo_error = status_next;
    assign res.param_count = seen_next;
    assign res.last        = ends;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR1;
            first_ok_reg <= 1'b0;
            sum_reg      <= '0;
            left_reg     <= '0;
            seen_reg     <= '0;
            status_reg   <= '0;
            idle_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            first_ok_reg <= first_ok_next;
            sum_reg      <= sum_next;
            left_reg     <= left_next;
            seen_reg     <= seen_next;
            status_reg   <= status_next;
            idle_reg     <= idle_next;
        end
    end

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("parse phase not one-hot");

    a_timeout_not_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.event_res == EV_TIMEOUT) |-> (phase_reg != PH_HDR1))
        else $error("timeout raised during header search");

    a_end_returns_to_search: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.last) |=> (phase_reg == PH_HDR1))
        else $error("packet end did not return to header search");

    a_param_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.event_res == EV_PARAM) |-> (!res.last && phase_reg == PH_PARAM))
        else $error("parameter event outside parameter phase or marked last");

endmodule

`default_nettype wire

// ===== sv/servo_status_packet_parser_unit.sv =====
// path: input register, parse logic, output register
// throughput: one request per cycle while the output register is free; ticks and header bytes may give no result
// reset: config to id 1 and 3000 ticks, parser in header search, pipeline empty
// top level: config registers, input and output registers around sspp_core
// depends on sspp_pkg, sspp_item_if, sspp_result_if, sspp_core
`timescale 1ns / 1ps
`default_nettype none

module servo_status_packet_parser_unit
    import sspp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    sspp_item_if.sink                  item,
    sspp_result_if.source              result
);

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;

    logic    out_free;
    logic    step_valid;
    logic    core_valid;
    result_t core_res;

    assign out_free   = !out_valid_reg || result.ready;
    assign step_valid = in_valid_reg && out_free;
    assign item.ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_id   <= EXPECTED_ID_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_EXPECTED_ID:   cfg_reg.expected_id   <= cfg_data[BYTE_W-1:0];
                CFG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data[TICK_W-1:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_item_reg.mode    <= item.mode;
            in_item_reg.rx_byte <= item.rx_byte;
        end
    end

    sspp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (step_valid),
        .step_item  (in_item_reg),
        .cfg        (cfg_reg),
        .res_valid  (core_valid),
        .res        (core_res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= core_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && core_valid)
        begin
            out_res_reg <= core_res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.event_res   = out_res_reg.event_res;
    assign result.data_byte   = out_res_reg.data_byte;
    assign result.param_index = out_res_reg.param_index;
    assign result.servo_error = out_res_reg.servo_error;
    assign result.param_count = out_res_reg.param_count;
    assign result.last        = out_res_reg.last;

    a_stalled_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_free) |=> in_valid_reg)
        else $error("pending request dropped while output stalled");

    a_no_step_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !step_valid)
        else $error("parse step taken while output register full");

    a_pending_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> (out_valid_reg && $stable(out_res_reg)))
        else $error("stalled result overwritten");

endmodule

`default_nettype wire

// ===== sim/sspp_status_checker.sv =====
// checker for the servo status packet parser: watches config writes and both channels,
// predicts parser events and compares them field by field in order
// depends on sspp_pkg, sspp_item_if and sspp_result_if
`timescale 1ns / 1ps

module sspp_status_checker
    import sspp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    sspp_item_if                  item,
    sspp_result_if                result,
    output int                    fail_count,
    output int                    outstanding,
    output int                    results_seen,
    output int                    packets_good,
    output int                    packets_bad
);

    cfg_t              cfg;
    phase_t            parse_phase;
    logic              hdr1_ok;
    logic [BYTE_W-1:0] csum_acc;
    logic [BYTE_W-1:0] params_todo;
    logic [BYTE_W-1:0] params_done;
    logic [BYTE_W-1:0] status_q;
    logic [TICK_W-1:0] tick_count;
    result_t           pending_events [$];

    // advances the parser copy by one request; returns 1 when an event comes out
    function automatic bit parse_step(input logic mode, input logic [BYTE_W-1:0] b,
                                      output result_t ev);
        logic [BYTE_W-1:0] idx;
        logic [BYTE_W-1:0] want_sum;
        bit                hit;
        hit = 1'b0;
        ev  = '0;
        if (mode)
        begin
            if (parse_phase != PH_HDR1)
            begin
                if (tick_count != TICK_MAX)
                    tick_count = tick_count + 16'd1;
                if (tick_count >= cfg.timeout_ticks)
                begin
                    ev.event_res = EV_TIMEOUT;
                    ev.last      = 1'b1;
                    hit          = 1'b1;
                end
            end
        end
        else
        begin
            tick_count = '0;
            case (parse_phase)
                PH_HDR1:
                begin
                    hdr1_ok     = (b == HDR_BYTE);
                    csum_acc    = '0;
                    params_todo = '0;
                    params_done = '0;
                    status_q    = '0;
                    parse_phase = PH_HDR2;
                end
                PH_HDR2:
                begin
                    if (!hdr1_ok || b != HDR_BYTE)
                    begin
                        ev.event_res = EV_HEADER;
                        ev.last      = 1'b1;
                        hit          = 1'b1;
                    end
                    else
                        parse_phase = PH_ID;
                end
                PH_ID:
                begin
                    if (b != cfg.expected_id)
                    begin
                        ev.event_res = EV_ID;
                        ev.last      = 1'b1;
                        hit          = 1'b1;
                    end
                    else
                    begin
                        csum_acc    = csum_acc + b;
                        parse_phase = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    csum_acc    = csum_acc + b;
                    params_todo = (b >= MIN_LEN) ? b - MIN_LEN : '0;
                    parse_phase = PH_STATUS;
                end
                PH_STATUS:
                begin
                    csum_acc    = csum_acc + b;
                    status_q    = b;
                    parse_phase = (params_todo != '0) ? PH_PARAM : PH_CSUM;
                end
                PH_PARAM:
                begin
                    idx         = params_done;
                    csum_acc    = csum_acc + b;
                    params_done = params_done + 8'd1;
                    params_todo = params_todo - 8'd1;
                    if (params_todo == '0)
                        parse_phase = PH_CSUM;
                    ev.event_res   = EV_PARAM;
                    ev.data_byte   = b;
                    ev.param_index = idx;
                    hit            = 1'b1;
                end
                PH_CSUM:
                begin
                    want_sum     = HDR_BYTE - csum_acc;
                    ev.event_res = (want_sum == b) ? EV_GOOD : EV_CSUM;
                    ev.last      = 1'b1;
                    hit          = 1'b1;
                end
                default:
                    parse_phase = PH_HDR1;
            endcase
        end
        if (hit)
        begin
            ev.servo_error = status_q;
            ev.param_count = params_done;
            if (ev.last)
                parse_phase = PH_HDR1;
        end
        return hit;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        result_t ev;
        if (!rst_n)
        begin
            cfg.expected_id   = EXPECTED_ID_RST;
            cfg.timeout_ticks = TIMEOUT_TICKS_RST;
            parse_phase       = PH_HDR1;
            hdr1_ok           = 1'b0;
            csum_acc          = '0;
            params_todo       = '0;
            params_done       = '0;
            status_q          = '0;
            tick_count        = '0;
            pending_events.delete();
            fail_count        = 0;
            outstanding       = 0;
            results_seen      = 0;
            packets_good      = 0;
            packets_bad       = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_EXPECTED_ID:   cfg.expected_id   = cfg_data[BYTE_W-1:0];
                    CFG_TIMEOUT_TICKS: cfg.timeout_ticks = cfg_data;
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                got.event_res   = event_t'(result.event_res);
                got.data_byte   = result.data_byte;
                got.param_index = result.param_index;
                got.servo_error = result.servo_error;
                got.param_count = result.param_count;
                got.last        = result.last;
                results_seen++;
                if (pending_events.size() == 0)
                begin
                    $error("unexpected result: event_res %0d", got.event_res);
                    fail_count++;
                end
                else
                begin
                    want = pending_events.pop_front();
                    check_field("event_res", want.event_res, got.event_res);
                    check_field("data_byte", want.data_byte, got.data_byte);
                    check_field("param_index", want.param_index, got.param_index);
                    check_field("servo_error", want.servo_error, got.servo_error);
                    check_field("param_count", want.param_count, got.param_count);
                    check_field("last", want.last, got.last);
                    if (want.last)
                    begin
                        if (want.event_res == EV_GOOD)
                            packets_good++;
                        else
                            packets_bad++;
                    end
                end
            end
            if (item.valid && item.ready)
            begin
                if (parse_step(item.mode, item.rx_byte, ev))
                    pending_events = {pending_events, ev};
            end
            outstanding = pending_events.size();
        end
    end

endmodule

// ===== sim/tb_servo_status_packet_parser_unit.sv =====
// testbench top for servo_status_packet_parser_unit: clock, reset, config writes,
// byte and tick stimulus with random stalls, verdict from sspp_status_checker
// depends on sspp_pkg, the two channel interfaces, the block and the checker
`timescale 1ns / 1ps

module tb_servo_status_packet_parser_unit;
    import sspp_pkg::*;

    localparam logic MODE_BYTE      = 1'b0;
    localparam logic MODE_TICK      = 1'b1;
    localparam int   WATCHDOG_LIMIT = 4000;
    localparam int   HOLDOFF_CYCLES = 300;
    localparam int   SETTLE_CYCLES  = 8;
    localparam int   PHASE_QUOTA    = 20;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int outstanding;
    int results_seen;
    int packets_good;
    int packets_bad;
    int requests_sent;
    bit calm;
    bit hold_req;

    sspp_item_if   item_ch ();
    sspp_result_if result_ch ();

    servo_status_packet_parser_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    sspp_status_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item_ch),
        .result       (result_ch),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .packets_good (packets_good),
        .packets_bad  (packets_bad)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic send_req(input logic mode, input logic [BYTE_W-1:0] b);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            item_ch.valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        item_ch.valid   = 1'b1;
        item_ch.mode    = mode;
        item_ch.rx_byte = b;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        @(negedge clk);
        requests_sent++;
    endtask

    // full status packet with a correct or broken checksum, ticks sprinkled between bytes
    task automatic send_packet(input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] len,
                               input logic [BYTE_W-1:0] status, input int tick_max,
                               input bit corrupt);
        logic [BYTE_W-1:0] body [$];
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] pbyte;
        logic [BYTE_W-1:0] csum_b;
        int                n_params;
        body     = '{HDR_BYTE, HDR_BYTE, id, len, status};
        sum      = id + len + status;
        n_params = (len >= MIN_LEN) ? len - MIN_LEN : 0;
        repeat (n_params)
        begin
            pbyte = 8'($urandom);
            body  = {body, pbyte};
            sum   = sum + pbyte;
        end
        csum_b = HDR_BYTE - sum;
        if (corrupt)
            csum_b = csum_b ^ 8'($urandom_range(1, 255));
        body = {body, csum_b};
        foreach (body[i])
        begin
            if (tick_max > 0 && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, tick_max)) send_req(MODE_TICK, 8'($urandom));
            send_req(MODE_BYTE, body[i]);
        end
    endtask

    // mostly well-formed packets, plus wrong ids, broken headers and loose noise
    task automatic random_phase(input logic [BYTE_W-1:0] id, input int tick_max);
        int start;
        start = requests_sent;
        while (requests_sent - start < PHASE_QUOTA)
        begin
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 6))
                       send_req(1'($urandom_range(0, 1)), 8'($urandom));
                1: send_packet(id ^ 8'($urandom_range(1, 255)), 8'($urandom_range(0, 12)),
                               8'($urandom), tick_max, 1'b0);
                2:
                begin
                    send_req(MODE_BYTE, HDR_BYTE);
                    send_req(MODE_BYTE, 8'($urandom_range(0, 254)));
                end
                default: send_packet(id, 8'($urandom_range(0, 12)), 8'($urandom), tick_max,
                                     $urandom_range(0, 5) == 0);
            endcase
        end
    endtask

    task automatic settle();
        item_ch.valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_cfg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    initial
    begin : sink_side
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_ch.ready = 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge clk);
                hold_req        = 1'b0;
                result_ch.ready = 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                result_ch.ready = 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge clk);
            end
            else
                result_ch.ready = 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("servo_status_packet_parser_unit regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        logic [BYTE_W-1:0] id;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        item_ch.valid   = 1'b0;
        item_ch.mode    = MODE_BYTE;
        item_ch.rx_byte = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: tick ignored in header search, header, id and checksum errors, short length, params
        send_req(MODE_TICK, HDR_BYTE);
        send_req(MODE_BYTE, 8'h00);
        send_req(MODE_BYTE, HDR_BYTE);
        send_req(MODE_BYTE, HDR_BYTE);
        send_req(MODE_BYTE, 8'h00);
        send_req(MODE_BYTE, HDR_BYTE);
        send_req(MODE_BYTE, HDR_BYTE);
        send_req(MODE_BYTE, 8'h02);
        send_packet(EXPECTED_ID_RST, 8'd0, 8'hFF, 0, 1'b0);
        send_packet(EXPECTED_ID_RST, 8'd3, 8'h00, 0, 1'b1);

        // receiver holds off while a long packet keeps coming
        hold_req = 1'b1;
        send_packet(EXPECTED_ID_RST, 8'd40, 8'($urandom), 0, 1'b0);
        random_phase(EXPECTED_ID_RST, 4);
        settle();

        write_cfg(CFG_EXPECTED_ID, 16'd0);
        write_cfg(CFG_TIMEOUT_TICKS, 16'd1);
        send_req(MODE_BYTE, HDR_BYTE);
        send_req(MODE_TICK, 8'h00);
        random_phase(8'd0, 3);
        settle();

        write_cfg(CFG_EXPECTED_ID, 16'd255);
        write_cfg(CFG_TIMEOUT_TICKS, TICK_MAX);
        send_packet(8'd255, 8'd255, 8'($urandom), 0, 1'b0);
        random_phase(8'd255, 6);
        settle();

        id = 8'($urandom);
        write_cfg(CFG_EXPECTED_ID, {8'd0, id});
        write_cfg(CFG_TIMEOUT_TICKS, 16'($urandom_range(2, 8)));
        random_phase(id, 10);
        settle();

        calm = 1'b1;
        id   = 8'($urandom);
        write_cfg(CFG_EXPECTED_ID, {8'd0, id});
        write_cfg(CFG_TIMEOUT_TICKS, 16'($urandom_range(1, 65535)));
        random_phase(id, 5);
        settle();

        $display("%0d requests under five register settings, %0d results checked",
                 requests_sent, results_seen);
        $display("%0d packets good, %0d ended in a header, id, checksum or timeout error",
                 packets_good, packets_bad);
        if (fail_count == 0)
            $display("servo_status_packet_parser_unit regression: pass");
        else
            $display("servo_status_packet_parser_unit regression: fail");
        $finish;
    end

endmodule
